@@ rtl/core/aoe_pkg.sv @@
// Package: sizes, types and command/status structs for the critical path block
`default_nettype none
package aoe_pkg;
  localparam int MaxEvents    = 16;
  localparam int MaxEdges     = 32;
  localparam int DurBits      = 16;
  localparam int EvW          = 4;
  localparam int EdgeW        = 5;
  localparam int CntW         = 6;
  localparam int TimeW        = 21;
  localparam int QW           = 5;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,      // clear in-degree and earliest tables
    OP_INDEG,      // count in-degree of edge at scan index
    OP_SEED,       // enqueue event at scan index if in-degree zero
    OP_POP,        // read queue head into current event
    OP_RELAX_K,    // Kahn decrement for edge at scan index
    OP_FWD,        // forward relax of edge at scan index
    OP_PROJ,       // fold event at scan index into project duration
    OP_LINIT,      // latest time of event at scan index = project duration
    OP_BWD,        // backward relax of edge at scan index
    OP_EMIT        // build result for edge at scan index
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [EdgeW-1:0] idx;      // edge or event index
    logic [QW-1:0]    qpos;     // topological position
    logic             qreset;   // reset queue head and tail
  } cmd_t;

  typedef struct packed {
    logic [QW-1:0]    tail;
    logic [QW-1:0]    head;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/core/aoe_dp.sv @@
// Datapath: edge store, in-degree, order queue and event time tables
`default_nettype none
module aoe_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               st_we,
  input  wire logic [aoe_pkg::EdgeW-1:0]          st_addr,
  input  wire logic [aoe_pkg::EvW-1:0]            st_from,
  input  wire logic [aoe_pkg::EvW-1:0]            st_to,
  input  wire logic [aoe_pkg::DurBits-1:0]        st_dur,
  input  wire aoe_pkg::cmd_t                      cmd,
  output aoe_pkg::sts_t                           sts,
  output logic [aoe_pkg::TimeW-1:0]               res_es,
  output logic [aoe_pkg::TimeW-1:0]               res_ls,
  output logic [aoe_pkg::TimeW-1:0]               res_slack,
  output logic [aoe_pkg::TimeW-1:0]               res_proj
);
  localparam int TW = aoe_pkg::TimeW;

  logic [aoe_pkg::EvW-1:0]     src_m [aoe_pkg::MaxEdges];
  logic [aoe_pkg::EvW-1:0]     dst_m [aoe_pkg::MaxEdges];
  logic [aoe_pkg::DurBits-1:0] len_m [aoe_pkg::MaxEdges];
  logic [aoe_pkg::CntW-1:0]    indeg_r [aoe_pkg::MaxEvents];
  logic [aoe_pkg::EvW-1:0]     order_r [aoe_pkg::MaxEvents];
  logic [TW-1:0]               et_r [aoe_pkg::MaxEvents];
  logic [TW-1:0]               lt_r [aoe_pkg::MaxEvents];
  logic [aoe_pkg::QW-1:0]      head_r, tail_r;
  logic [aoe_pkg::EvW-1:0]     cur_r;
  logic [TW-1:0]               proj_r;

  logic [aoe_pkg::EvW-1:0]     e_src, e_dst, ev;
  logic [aoe_pkg::DurBits-1:0] e_len;
  logic [TW-1:0]               fwd_t, bwd_c, ls_v, es_v;

  assign e_src = src_m[cmd.idx];
  assign e_dst = dst_m[cmd.idx];
  assign e_len = len_m[cmd.idx];
  assign ev    = cmd.idx[aoe_pkg::EvW-1:0];
  assign fwd_t = et_r[cur_r] + TW'(e_len);
  assign bwd_c = (lt_r[e_dst] >= TW'(e_len)) ? lt_r[e_dst] - TW'(e_len) : '0;
  assign es_v  = et_r[e_src];
  assign ls_v  = bwd_c;

  // edge store writes
  always_ff @(posedge clk) begin
    if (st_we) begin
      src_m[st_addr] <= st_from;
      dst_m[st_addr] <= st_to;
      len_m[st_addr] <= st_dur;
    end
  end

  // table operations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (cmd.qreset) begin
        head_r <= '0;
        tail_r <= '0;
      end
      case (cmd.op)
        aoe_pkg::OP_CLEAR: begin
          for (int i = 0; i < aoe_pkg::MaxEvents; i++) begin
            indeg_r[i] <= '0;
            et_r[i]    <= '0;
          end
          proj_r <= '0;
        end
        aoe_pkg::OP_INDEG: indeg_r[e_dst] <= indeg_r[e_dst] + 1'b1;
        aoe_pkg::OP_SEED: begin
          if (indeg_r[ev] == '0) begin
            order_r[tail_r[aoe_pkg::EvW-1:0]] <= ev;
            tail_r <= tail_r + 1'b1;
          end
        end
        aoe_pkg::OP_POP: begin
          cur_r  <= order_r[head_r[aoe_pkg::EvW-1:0]];
          head_r <= head_r + 1'b1;
        end
        aoe_pkg::OP_RELAX_K: begin
          if (e_src == cur_r) begin
            indeg_r[e_dst] <= indeg_r[e_dst] - 1'b1;
            if (indeg_r[e_dst] == aoe_pkg::CntW'(1) && tail_r < aoe_pkg::QW'(aoe_pkg::MaxEvents)) begin
              order_r[tail_r[aoe_pkg::EvW-1:0]] <= e_dst;
              tail_r <= tail_r + 1'b1;
            end
          end
        end
        aoe_pkg::OP_FWD: begin
          if (e_src == cur_r && fwd_t > et_r[e_dst]) et_r[e_dst] <= fwd_t;
        end
        aoe_pkg::OP_PROJ: if (et_r[ev] > proj_r) proj_r <= et_r[ev];
        aoe_pkg::OP_LINIT: lt_r[ev] <= proj_r;
        aoe_pkg::OP_BWD: begin
          if (e_src == cur_r && bwd_c < lt_r[cur_r]) lt_r[cur_r] <= bwd_c;
        end
        aoe_pkg::OP_EMIT: begin
          res_es    <= es_v;
          res_ls    <= ls_v;
          res_slack <= (ls_v >= es_v) ? ls_v - es_v : '0;
          res_proj  <= proj_r;
        end
        default: ;
      endcase
      // forward/backward passes pick current event by queue position
      if (cmd.op == aoe_pkg::OP_NONE && !cmd.qreset)
        cur_r <= order_r[cmd.qpos[aoe_pkg::EvW-1:0]];
    end
  end

  assign sts.tail = tail_r;
  assign sts.head = head_r;
endmodule
`default_nettype wire

@@ rtl/core/aoe_ctrl.sv @@
// Controller: load sequencing, sort and pass sequencing, result handshake
`default_nettype none
module aoe_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [aoe_pkg::EvW-1:0]       from_ok_ev,
  input  wire logic [aoe_pkg::EvW-1:0]       to_ok_ev,
  input  wire logic                          in_last,
  input  wire logic [4:0]                    ev_count,
  output logic                               st_we,
  output logic [aoe_pkg::EdgeW-1:0]          st_addr,
  output aoe_pkg::cmd_t                      cmd,
  input  wire aoe_pkg::sts_t                 sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [aoe_pkg::EdgeW-1:0]          out_idx,
  output logic                               out_err,
  output logic                               out_lastr
);
  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_INDEG, S_SEED, S_POP, S_KAHN, S_CHK, S_FSEL, S_FWD,
    S_PROJ, S_LINIT, S_BSEL, S_BWD, S_EMIT, S_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [aoe_pkg::CntW-1:0]    cnt_r, cnt_nxt;       // edges loaded
  logic                        lerr_r, lerr_nxt;
  logic [aoe_pkg::EdgeW:0]     i_r, i_nxt;           // scan index
  logic [aoe_pkg::QW-1:0]      k_r, k_nxt;           // topological position
  logic                        ov_r, ov_nxt;
  logic [aoe_pkg::EdgeW-1:0]   oi_r, oi_nxt;
  logic                        oe_r, oe_nxt, ol_r, ol_nxt;
  logic [aoe_pkg::QW-1:0]      n;
  logic                        acc, bad;
  logic [aoe_pkg::EdgeW:0]     ecnt;

  assign n    = (ev_count > 5'd16) ? aoe_pkg::QW'(16) : ev_count;
  assign acc  = in_valid && !in_stall;
  assign bad  = ({1'b0, from_ok_ev} >= n) || ({1'b0, to_ok_ev} >= n) ||
                (cnt_r >= aoe_pkg::CntW'(aoe_pkg::MaxEdges));
  assign ecnt = cnt_r;
  assign in_stall = (state_r != S_LOAD) || (ov_r && out_stall);
  assign st_we    = acc && !bad;
  assign st_addr  = cnt_r[aoe_pkg::EdgeW-1:0];
  assign out_valid = ov_r;
  assign out_idx   = oi_r;
  assign out_err   = oe_r;
  assign out_lastr = ol_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; lerr_nxt = lerr_r; i_nxt = i_r; k_nxt = k_r;
    ov_nxt = ov_r && out_stall; oi_nxt = oi_r; oe_nxt = oe_r; ol_nxt = ol_r;
    cmd = '{op: aoe_pkg::OP_NONE, idx: i_r[aoe_pkg::EdgeW-1:0], qpos: k_r, qreset: 1'b0};
    unique case (state_r)
      S_LOAD: begin
        if (acc) begin
          if (bad) lerr_nxt = 1'b1; else cnt_nxt = cnt_r + 1'b1;
          if (in_last) begin
            if (bad || lerr_r) begin
              ov_nxt = 1'b1; oi_nxt = '0; oe_nxt = 1'b1; ol_nxt = 1'b1;
              cnt_nxt = '0; lerr_nxt = 1'b0;
            end else state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.op = aoe_pkg::OP_CLEAR; cmd.qreset = 1'b1;
        i_nxt = '0; state_nxt = S_INDEG;
      end
      S_INDEG: begin
        if (i_r == ecnt) begin i_nxt = '0; state_nxt = S_SEED; end
        else begin cmd.op = aoe_pkg::OP_INDEG; i_nxt = i_r + 1'b1; end
      end
      S_SEED: begin
        if (i_r == (aoe_pkg::EdgeW+1)'(n)) state_nxt = S_POP;
        else begin cmd.op = aoe_pkg::OP_SEED; i_nxt = i_r + 1'b1; end
      end
      S_POP: begin
        if (sts.head == sts.tail) state_nxt = S_CHK;
        else begin cmd.op = aoe_pkg::OP_POP; i_nxt = '0; state_nxt = S_KAHN; end
      end
      S_KAHN: begin
        if (i_r == ecnt) state_nxt = S_POP;
        else begin cmd.op = aoe_pkg::OP_RELAX_K; i_nxt = i_r + 1'b1; end
      end
      S_CHK: begin
        if (sts.tail < n) begin
          ov_nxt = 1'b1; oi_nxt = '0; oe_nxt = 1'b1; ol_nxt = 1'b1;
          cnt_nxt = '0; lerr_nxt = 1'b0; state_nxt = S_OUT;
        end else begin k_nxt = '0; state_nxt = S_FSEL; end
      end
      S_FSEL: begin
        if (k_r == n) begin i_nxt = '0; state_nxt = S_PROJ; end
        else begin i_nxt = '0; state_nxt = S_FWD; end
      end
      S_FWD: begin
        if (i_r == ecnt) begin k_nxt = k_r + 1'b1; state_nxt = S_FSEL; end
        else begin cmd.op = aoe_pkg::OP_FWD; i_nxt = i_r + 1'b1; end
      end
      S_PROJ: begin
        if (i_r == (aoe_pkg::EdgeW+1)'(n)) begin i_nxt = '0; state_nxt = S_LINIT; end
        else begin cmd.op = aoe_pkg::OP_PROJ; i_nxt = i_r + 1'b1; end
      end
      S_LINIT: begin
        if (i_r == (aoe_pkg::EdgeW+1)'(n)) begin k_nxt = n; state_nxt = S_BSEL; end
        else begin cmd.op = aoe_pkg::OP_LINIT; i_nxt = i_r + 1'b1; end
      end
      S_BSEL: begin
        cmd.qpos = k_r - 1'b1;
        if (k_r == '0) begin i_nxt = '0; state_nxt = S_EMIT; end
        else begin i_nxt = '0; state_nxt = S_BWD; end
      end
      S_BWD: begin
        if (i_r == ecnt) begin k_nxt = k_r - 1'b1; state_nxt = S_BSEL; end
        else begin cmd.op = aoe_pkg::OP_BWD; i_nxt = i_r + 1'b1; end
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          cmd.op = aoe_pkg::OP_EMIT;
          ov_nxt = 1'b1; oi_nxt = i_r[aoe_pkg::EdgeW-1:0]; oe_nxt = 1'b0;
          ol_nxt = (i_r + 1'b1 == ecnt);
          i_nxt = i_r + 1'b1;
          if (i_r + 1'b1 == ecnt) begin
            cnt_nxt = '0; lerr_nxt = 1'b0; state_nxt = S_OUT;
          end
        end
      end
      S_OUT: if (!ov_nxt) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
    // in select states the current event follows the queue position
    if (state_r == S_FSEL) cmd.qpos = k_r;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; lerr_r <= 1'b0; ov_r <= 1'b0;
      i_r <= '0; k_r <= '0; oi_r <= '0; oe_r <= 1'b0; ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; lerr_r <= lerr_nxt; ov_r <= ov_nxt;
      i_r <= i_nxt; k_r <= k_nxt; oi_r <= oi_nxt; oe_r <= oe_nxt; ol_r <= ol_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/aoe_critical_path_slack.sv @@
// Top level: critical path and slack of an activity-on-edge network
// Operation: edges load with no result; the last edge starts a run of clear, in-degree
//   count, seed, Kahn sort, forward and backward passes and emit; no edge is taken
//   until it ends, and a cycle in the graph ends the run right after the sort.
// Throughput: one edge per cycle in load, one result per cycle out, if no word stalls.
// Reset: synchronous active low; clears control, event count returns to 16.
`default_nettype none
module aoe_critical_path_slack (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_from_event,
  input  wire logic [3:0]  in_to_event,
  input  wire logic [15:0] in_duration,
  input  wire logic        in_last_edge,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_event_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_edge_index,
  output logic [20:0]      out_earliest_start,
  output logic [20:0]      out_latest_start,
  output logic [20:0]      out_slack,
  output logic             out_critical,
  output logic [20:0]      out_project_duration,
  output logic             out_graph_error,
  output logic             out_last_result
);
  logic [4:0]     evc_r;
  logic           st_we, err;
  logic [4:0]     st_addr;
  aoe_pkg::cmd_t  cmd;
  aoe_pkg::sts_t  sts;
  logic [20:0]    es, ls, sl, pj;

  // event count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) evc_r <= 5'd16;
    else if (cfg_valid) evc_r <= cfg_event_count;
  end

  aoe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .from_ok_ev(in_from_event), .to_ok_ev(in_to_event), .in_last(in_last_edge),
    .ev_count(evc_r), .st_we, .st_addr, .cmd, .sts,
    .out_valid, .out_stall, .out_idx(out_edge_index), .out_err(err),
    .out_lastr(out_last_result)
  );

  aoe_dp u_dp (
    .clk, .rst_n, .st_we, .st_addr, .st_from(in_from_event), .st_to(in_to_event),
    .st_dur(in_duration), .cmd, .sts,
    .res_es(es), .res_ls(ls), .res_slack(sl), .res_proj(pj)
  );

  // error word has all other fields zero but the last flag
  assign out_graph_error      = err;
  assign out_earliest_start   = err ? '0 : es;
  assign out_latest_start     = err ? '0 : ls;
  assign out_slack            = err ? '0 : sl;
  assign out_critical         = err ? 1'b0 : (sl == '0);
  assign out_project_duration = err ? '0 : pj;
endmodule
`default_nettype wire

@@ tb/sv/aoe_critical_path_slack_tb.sv @@
// Testbench for the critical path and slack block: scoreboard with its own predictor
`timescale 1ns / 1ps
module aoe_critical_path_slack_tb;

  typedef struct packed {
    bit [4:0]                idx;
    bit [aoe_pkg::TimeW-1:0] es;
    bit [aoe_pkg::TimeW-1:0] ls;
    bit [aoe_pkg::TimeW-1:0] sl;
    bit                      crit;
    bit [aoe_pkg::TimeW-1:0] proj;
    bit                      err;
    bit                      last;
  } edge_report_t;

  // Holds the activity table, predicts the per-edge reports and compares them
  class cpm_scoreboard;
    bit [4:0]     event_count = 5'd16;
    bit [3:0]     src[aoe_pkg::MaxEdges];
    bit [3:0]     dst[aoe_pkg::MaxEdges];
    longint       len[aoe_pkg::MaxEdges];
    int           loaded;
    bit           load_err;
    edge_report_t pending_reports[$];
    int           mismatches;
    int           unexpected;
    int           checked;
    int           error_reports;
    int           graphs;

    function int used_events();
      return (event_count < aoe_pkg::MaxEvents) ? int'(event_count) : aoe_pkg::MaxEvents;
    endfunction

    // Append one expected word
    function void add_report(edge_report_t r);
      pending_reports = {pending_reports, r};
    endfunction

    // Critical path: Kahn order, forward and backward passes, per-edge reports
    function bit predict_schedule();
      int           n;
      int           indeg[aoe_pkg::MaxEvents];
      int           order[aoe_pkg::MaxEvents];
      longint       early[aoe_pkg::MaxEvents];
      longint       late[aoe_pkg::MaxEvents];
      int           head;
      int           tail;
      int           u;
      int           v;
      longint       proj;
      longint       c;
      longint       es;
      longint       ls;
      longint       sl;
      edge_report_t r;
      n = used_events();
      head = 0;
      tail = 0;
      proj = 0;
      for (int i = 0; i < aoe_pkg::MaxEvents; i++) begin
        indeg[i] = 0;
        early[i] = 0;
        order[i] = 0;
      end
      for (int e = 0; e < loaded; e++) indeg[dst[e]]++;
      for (int i = 0; i < n; i++)
        if (indeg[i] == 0) begin
          order[tail] = i;
          tail++;
        end
      while (head < tail) begin
        u = order[head];
        head++;
        for (int e = 0; e < loaded; e++) begin
          if (src[e] != u) continue;
          v = dst[e];
          indeg[v]--;
          if (indeg[v] == 0 && tail < aoe_pkg::MaxEvents) begin
            order[tail] = v;
            tail++;
          end
        end
      end
      if (tail < n) return 1'b0;
      // forward pass
      for (int k = 0; k < n; k++) begin
        u = order[k];
        for (int e = 0; e < loaded; e++)
          if (src[e] == u && early[u] + len[e] > early[dst[e]])
            early[dst[e]] = early[u] + len[e];
      end
      for (int i = 0; i < n; i++) if (early[i] > proj) proj = early[i];
      for (int i = 0; i < aoe_pkg::MaxEvents; i++) late[i] = proj;
      // backward pass
      for (int k = n; k > 0; k--) begin
        u = order[k-1];
        for (int e = 0; e < loaded; e++) begin
          if (src[e] != u) continue;
          c = (late[dst[e]] >= len[e]) ? late[dst[e]] - len[e] : 0;
          if (c < late[u]) late[u] = c;
        end
      end
      for (int e = 0; e < loaded; e++) begin
        es = early[src[e]];
        ls = (late[dst[e]] >= len[e]) ? late[dst[e]] - len[e] : 0;
        sl = (ls >= es) ? ls - es : 0;
        r.idx  = e[4:0];
        r.es   = es[aoe_pkg::TimeW-1:0];
        r.ls   = ls[aoe_pkg::TimeW-1:0];
        r.sl   = sl[aoe_pkg::TimeW-1:0];
        r.crit = (sl == 0);
        r.proj = proj[aoe_pkg::TimeW-1:0];
        r.err  = 1'b0;
        r.last = (e + 1 == loaded);
        add_report(r);
      end
      return 1'b1;
    endfunction

    // Accepted activity word
    function void note_edge(bit [3:0] from_ev, bit [3:0] to_ev, bit [15:0] dur, bit last);
      edge_report_t r;
      int n;
      n = used_events();
      if (from_ev >= n || to_ev >= n || loaded >= aoe_pkg::MaxEdges) begin
        load_err = 1'b1;
      end else begin
        src[loaded] = from_ev;
        dst[loaded] = to_ev;
        len[loaded] = dur;
        loaded++;
      end
      if (!last) return;
      graphs++;
      if (load_err || !predict_schedule()) begin
        r = '0;
        r.err  = 1'b1;
        r.last = 1'b1;
        add_report(r);
        error_reports++;
      end
      loaded = 0;
      load_err = 1'b0;
    endfunction

    // Accepted result word against the oldest prediction
    function void check_result(edge_report_t got);
      edge_report_t want;
      if (pending_reports.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: edge %0d err %0d", got.idx, got.err);
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got != want) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          $display("mismatch: exp idx %0d es %0d ls %0d sl %0d crit %0d proj %0d err %0d last %0d",
                   want.idx, want.es, want.ls, want.sl, want.crit, want.proj, want.err,
                   want.last);
          $display("          got idx %0d es %0d ls %0d sl %0d crit %0d proj %0d err %0d last %0d",
                   got.idx, got.es, got.ls, got.sl, got.crit, got.proj, got.err, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_from_event = '0;
  logic [3:0]  in_to_event = '0;
  logic [15:0] in_duration = '0;
  logic        in_last_edge = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_event_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_edge_index;
  logic [20:0] out_earliest_start;
  logic [20:0] out_latest_start;
  logic [20:0] out_slack;
  logic        out_critical;
  logic [20:0] out_project_duration;
  logic        out_graph_error;
  logic        out_last_result;

  cpm_scoreboard sb = new();
  bit idle_on = 1'b1;
  int long_hold = 0;
  int items_sent = 0;

  aoe_critical_path_slack uut (.*);

  always #5 clk = ~clk;

  // Result side: checks accepted words and stalls in bursts or one long hold
  initial begin
    edge_report_t got;
    int stall_left;
    bit nxt;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.idx  = out_edge_index;
        got.es   = out_earliest_start;
        got.ls   = out_latest_start;
        got.sl   = out_slack;
        got.crit = out_critical;
        got.proj = out_project_duration;
        got.err  = out_graph_error;
        got.last = out_last_result;
        sb.check_result(got);
      end
      if (long_hold > 0) begin
        long_hold--;
        nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        nxt = 1'b1;
      end else begin
        nxt = 1'b0;
      end
      out_stall <= nxt;
    end
  end

  // Offer one activity word and hold it until taken
  task automatic send_edge(bit [3:0] from_ev, bit [3:0] to_ev, bit [15:0] dur, bit last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_from_event <= from_ev;
    in_to_event   <= to_ev;
    in_duration   <= dur;
    in_last_edge  <= last;
    do @(posedge clk); while (in_stall);
    sb.note_edge(from_ev, to_ev, dur, last);
    items_sent++;
  endtask

  // Drain all predicted words and let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_event_count(bit [4:0] cnt);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_event_count <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.event_count = cnt;
  endtask

  function automatic bit [15:0] rand_dur();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
  endfunction

  // One graph: mostly forward edges (acyclic), some noise edges
  task automatic random_graph(int edges, int noise_pct);
    int n;
    bit [3:0] f;
    bit [3:0] t;
    n = sb.used_events();
    for (int i = 0; i < edges; i++) begin
      if (n < 2 || $urandom_range(0, 99) < noise_pct) begin
        f = 4'($urandom);
        t = 4'($urandom);
      end else begin
        f = 4'($urandom_range(0, n - 2));
        t = 4'($urandom_range(f + 1, n - 1));
      end
      send_edge(f, t, rand_dur(), i == edges - 1);
    end
  endtask

  initial begin
    int phase_counts[6];
    int targets[6];
    int sz;
    phase_counts = '{16, 7, 31, 2, 12, 16};
    targets      = '{60, 100, 150, 180, 220, 265};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, ties, isolated events, cycles, self-loop, range errors
    send_edge(4'd0, 4'd1, 16'hFFFF, 1'b0);
    send_edge(4'd1, 4'd15, 16'd0, 1'b0);
    send_edge(4'd0, 4'd15, 16'd5, 1'b1);
    send_edge(4'd0, 4'd1, 16'd7, 1'b0);
    send_edge(4'd0, 4'd2, 16'd7, 1'b0);
    send_edge(4'd1, 4'd3, 16'd3, 1'b0);
    send_edge(4'd2, 4'd3, 16'd3, 1'b1);
    send_edge(4'd3, 4'd3, 16'd1, 1'b1);
    send_edge(4'd1, 4'd2, 16'd4, 1'b0);
    send_edge(4'd2, 4'd1, 16'd4, 1'b1);
    send_edge(4'd14, 4'd15, 16'hAAAA, 1'b1);
    set_event_count(5'd4);
    send_edge(4'd0, 4'd3, 16'h5555, 1'b0);
    send_edge(4'd5, 4'd1, 16'd2, 1'b1);
    send_edge(4'd1, 4'd15, 16'd2, 1'b1);
    send_edge(4'd0, 4'd3, 16'd9, 1'b1);
    set_event_count(5'd1);
    send_edge(4'd0, 4'd0, 16'd1, 1'b1);
    set_event_count(5'd0);
    send_edge(4'd0, 4'd0, 16'd1, 1'b1);

    // Random phases across event counts; the last phase runs without idling
    for (int p = 0; p < 6; p++) begin
      set_event_count(5'(phase_counts[p]));
      if (p == 5) idle_on = 1'b0;
      if (p == 1) long_hold = 400;
      while (items_sent < targets[p]) begin
        case ($urandom_range(0, 19)) inside
          0:       sz = aoe_pkg::MaxEdges + $urandom_range(1, 2);
          1:       sz = aoe_pkg::MaxEdges;
          [2:3]:   sz = $urandom_range(9, 24);
          default: sz = $urandom_range(1, 8);
        endcase
        random_graph(sz, ($urandom_range(0, 4) == 0) ? 40 : 0);
        if (p == 3 && items_sent > 160 && items_sent < 170) drain_results();
      end
    end

    drain_results();
    $display("graphs %0d, result words checked %0d, error reports %0d, edges sent %0d",
             sb.graphs, sb.checked, sb.error_reports, items_sent);
    $display("mismatches %0d, unexpected %0d, left over %0d",
             sb.mismatches, sb.unexpected, sb.pending_reports.size());
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end
endmodule
